>>> hdl/mcbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcbb_pkg;

  localparam int IMG_W_BITS   = 13;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DAT_BITS = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MATCH_MASK    = 3'd0,
    CFG_MATCH_COLOR   = 3'd1,
    CFG_FIND_MATCH    = 3'd2,
    CFG_SWAP_RED_BLUE = 3'd3,
    CFG_IMAGE_WIDTH   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic        frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [11:0] box_x;
    logic [11:0] box_y;
    logic [12:0] box_w;
    logic [12:0] box_h;
  } box_out_t;

  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] color;
    logic        find;
    logic        swap;
  } match_cfg_t;

  typedef struct packed {
    logic step;
    logic hit;
    logic last;
  } trk_ctl_t;

endpackage

`default_nettype wire

>>> hdl/masked_color_bounding_box_unit.sv
// Masked color bounding box.
// Pixels of a frame enter in raster order on the in_ channel, one word per
// cycle, with frame_end set on the last pixel. Each pixel is tested against
// the mask and color registers; the block tracks the extent of the selected
// pixels. The pixel carrying frame_end yields one word on the out_ channel:
// the bounding box, or all zeros when no pixel was selected. Other pixels
// yield nothing.
// The last pixel is first held in the input register; the result register
// loads the box when that pixel leaves it. Throughput: one pixel per cycle.
// A stall on out_ready holds in_ready low only once a frame-end pixel sits
// in the input register while the result register is still full.
// Configuration is written through cfg_ (always ready); the user must write
// it only while no frame is in flight, which the block does not enforce.
// Reset restores the register defaults (mask all ones, color zero, find set,
// no swap, width 4096) and clears position and bounds.
`timescale 1ns / 1ps
`default_nettype none

module masked_color_bounding_box_unit import mcbb_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire pix_in_t                 in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output box_out_t                     out_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DAT_BITS-1:0] cfg_data
);

  match_cfg_t            mcfg_r, mcfg_nxt;
  logic [IMG_W_BITS-1:0] width_r, width_nxt;

  logic     s1_valid_r, s1_valid_nxt;
  pix_in_t  s1_r;
  logic     s1_fire;
  logic     in_fire;
  logic     hit;
  trk_ctl_t ctl;
  box_out_t box;
  logic     out_valid_r, out_valid_nxt;
  box_out_t out_data_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    mcfg_nxt  = mcfg_r;
    width_nxt = width_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MATCH_MASK:    mcfg_nxt.mask  = cfg_data;
        CFG_MATCH_COLOR:   mcfg_nxt.color = cfg_data;
        CFG_FIND_MATCH:    mcfg_nxt.find  = cfg_data[0];
        CFG_SWAP_RED_BLUE: mcfg_nxt.swap  = cfg_data[0];
        CFG_IMAGE_WIDTH:   width_nxt      = cfg_data[IMG_W_BITS-1:0];
        default: ;
      endcase
    end
  end

  // a frame-end word may leave the input register only if the result slot frees up
  assign s1_fire  = s1_valid_r && (!s1_r.frame_end || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  mcbb_match u_match (
    .cfg        (mcfg_r),
    .pixel_word (s1_r.pixel_word),
    .hit        (hit)
  );

  always_comb begin
    ctl.step = s1_fire;
    ctl.hit  = hit;
    ctl.last = s1_r.frame_end;
  end

  mcbb_track #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .image_width (width_r),
    .box         (box)
  );

  always_comb begin
    if (s1_fire && s1_r.frame_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcfg_r.mask  <= '1;
      mcfg_r.color <= '0;
      mcfg_r.find  <= 1'b1;
      mcfg_r.swap  <= 1'b0;
      width_r      <= IMG_W_BITS'(4096);
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      mcfg_r      <= mcfg_nxt;
      width_r     <= width_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= in_data;
    end
    if (s1_fire && s1_r.frame_end) begin
      out_data_r <= box;
    end
  end

  // the input side stalls only behind a frame-end word blocked by a full result slot
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_r.frame_end && out_valid_r && !out_ready))
    else $error("input stalled without a blocked frame-end word");

  // every frame-end word that leaves the input register presents a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_r.frame_end) |=> out_valid_r)
    else $error("frame end produced no result");

  // a result appears only after a frame-end word has left the input register
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> $past(s1_fire && s1_r.frame_end))
    else $error("result without a frame end");

endmodule

`default_nettype wire

>>> hdl/mcbb_match.sv
`timescale 1ns / 1ps
`default_nettype none

module mcbb_match import mcbb_pkg::*; (
  input  wire match_cfg_t  cfg,
  input  wire logic [31:0] pixel_word,
  output logic             hit
);

  logic [31:0] mask_eff;
  logic [31:0] color_eff;

  // exchange bytes 0 and 2 when the swap flag is set
  always_comb begin
    if (cfg.swap) begin
      mask_eff  = {cfg.mask[31:24], cfg.mask[7:0], cfg.mask[15:8], cfg.mask[23:16]};
      color_eff = {cfg.color[31:24], cfg.color[7:0], cfg.color[15:8], cfg.color[23:16]};
    end else begin
      mask_eff  = cfg.mask;
      color_eff = cfg.color;
    end
  end

  assign hit = (((pixel_word & mask_eff) == color_eff) == cfg.find);

endmodule

`default_nettype wire

>>> hdl/mcbb_track.sv
`timescale 1ns / 1ps
`default_nettype none

module mcbb_track import mcbb_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire trk_ctl_t              ctl,
  input  wire logic [IMG_W_BITS-1:0] image_width,
  output box_out_t                   box
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int EW0 = (WW > IMG_W_BITS) ? WW : IMG_W_BITS;
  localparam int EW  = (EW0 > CW + 1) ? EW0 : CW + 1;
  localparam int XW  = (CW > 12) ? CW : 12;
  localparam int YW  = (RW > 12) ? RW : 12;
  localparam int DXW = (CW + 1 > 13) ? CW + 1 : 13;
  localparam int DYW = (RW + 1 > 13) ? RW + 1 : 13;
  localparam logic [EW-1:0] MAXW   = EW'(MAX_WIDTH);
  localparam logic [RW-1:0] LASTRW = RW'(MAX_HEIGHT - 1);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          any_r, any_nxt;
  logic [CW-1:0] lx_r, lx_nxt, gx_r, gx_nxt;
  logic [RW-1:0] ly_r, ly_nxt, gy_r, gy_nxt;

  logic          any_upd;
  logic [CW-1:0] lx_upd, gx_upd;
  logic [RW-1:0] ly_upd, gy_upd;
  logic [EW-1:0] width_eff;
  logic          col_wrap;
  logic [XW-1:0] x_ext;
  logic [YW-1:0] y_ext;
  logic [DXW-1:0] w_full;
  logic [DYW-1:0] h_full;

  // a zero or out-of-range width falls back to the maximum
  always_comb begin
    if (image_width == '0 || EW'(image_width) > MAXW) begin
      width_eff = MAXW;
    end else begin
      width_eff = EW'(image_width);
    end
  end

  assign col_wrap = (EW'(col_r) + EW'(1)) >= width_eff;

  // fold the current pixel into the bounds
  always_comb begin
    any_upd = any_r;
    lx_upd  = lx_r;
    gx_upd  = gx_r;
    ly_upd  = ly_r;
    gy_upd  = gy_r;
    if (ctl.hit) begin
      any_upd = 1'b1;
      if (!any_r) begin
        lx_upd = col_r;
        gx_upd = col_r;
        ly_upd = row_r;
        gy_upd = row_r;
      end else begin
        if (col_r < lx_r) lx_upd = col_r;
        if (col_r > gx_r) gx_upd = col_r;
        if (row_r < ly_r) ly_upd = row_r;
        if (row_r > gy_r) gy_upd = row_r;
      end
    end
  end

  always_comb begin
    x_ext  = XW'(lx_upd);
    y_ext  = YW'(ly_upd);
    w_full = DXW'(gx_upd) - DXW'(lx_upd) + DXW'(1);
    h_full = DYW'(gy_upd) - DYW'(ly_upd) + DYW'(1);
    if (any_upd) begin
      box.box_x = x_ext[11:0];
      box.box_y = y_ext[11:0];
      box.box_w = w_full[12:0];
      box.box_h = h_full[12:0];
    end else begin
      box = '0;
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    any_nxt = any_r;
    lx_nxt  = lx_r;
    gx_nxt  = gx_r;
    ly_nxt  = ly_r;
    gy_nxt  = gy_r;
    if (ctl.step) begin
      if (ctl.last) begin
        // clear for the next frame
        col_nxt = '0;
        row_nxt = '0;
        any_nxt = 1'b0;
        lx_nxt  = '0;
        gx_nxt  = '0;
        ly_nxt  = '0;
        gy_nxt  = '0;
      end else begin
        any_nxt = any_upd;
        lx_nxt  = lx_upd;
        gx_nxt  = gx_upd;
        ly_nxt  = ly_upd;
        gy_nxt  = gy_upd;
        if (col_wrap) begin
          col_nxt = '0;
          if (row_r != LASTRW) row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      any_r <= 1'b0;
      lx_r  <= '0;
      gx_r  <= '0;
      ly_r  <= '0;
      gy_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      any_r <= any_nxt;
      lx_r  <= lx_nxt;
      gx_r  <= gx_nxt;
      ly_r  <= ly_nxt;
      gy_r  <= gy_nxt;
    end
  end

endmodule

`default_nettype wire
